FILE: rtl/etmb_pkg.sv
// ============================================================================
// etmb_pkg
// Shared widths, types and the sine table generator for the Euler TRS
// matrix builder.
// ============================================================================
package etmb_pkg;

    // Default configuration
    localparam int unsigned ANGLE_BITS_DEF      = 16;
    localparam int unsigned SINE_TABLE_BITS_DEF = 10;

    // Field widths fixed by the interface
    localparam int unsigned POS_W   = 32;
    localparam int unsigned ANGLE_W = 16;
    localparam int unsigned SCALE_W = 16;
    localparam int unsigned COL_W   = 32;

    // Table entry: unsigned Q1.16, at most 1.0
    localparam int unsigned TBL_VAL_W = 17;
    // Signed trig value: -1.0 .. +1.0 in Q16
    localparam int unsigned TRIG_W    = 18;

    // pi/2 in Q62
    localparam logic [63:0] HALF_PI_Q62 = 64'h6487_ED51_10B4_611A;

    // Sine and cosine of one angle, signed Q16
    typedef struct packed {
        logic signed [TRIG_W-1:0] sin_q;
        logic signed [TRIG_W-1:0] cos_q;
    } t_trig;

    // Side data that travels alongside the rotation work
    typedef struct packed {
        logic signed [POS_W-1:0]   pos_x;
        logic signed [POS_W-1:0]   pos_y;
        logic signed [POS_W-1:0]   pos_z;
        logic signed [SCALE_W-1:0] scale_x;
        logic signed [SCALE_W-1:0] scale_y;
        logic signed [SCALE_W-1:0] scale_z;
    } t_side;

    // Unsigned Q62 product, elaboration only
    function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] wide;
        wide = {64'd0, a} * {64'd0, b};
        return wide[125:62];
    endfunction

    // Entry idx of the quarter-wave table: sin(pi/2 * idx / 2^tbits) in Q1.16,
    // from a twenty-one-term Taylor series in Q62. Evaluated at elaboration.
    function automatic logic [TBL_VAL_W-1:0] sine_entry(input int unsigned idx,
                                                        input int unsigned tbits);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] lowmask;
        logic [63:0] rnd;
        lowmask = (64'd1 << tbits) - 64'd1;
        x = (HALF_PI_Q62 >> tbits) * 64'(idx)
          + (((HALF_PI_Q62 & lowmask) * 64'(idx)) >> tbits);
        x2   = mul_q62(x, x);
        term = x;
        sum  = x;
        for (int unsigned k = 1; k <= 20; k++) begin
            term = mul_q62(term, x2) / 64'((2 * k) * (2 * k + 1));
            if (k[0]) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        rnd = (sum + (64'd1 << 45)) >> 46;
        return rnd[TBL_VAL_W-1:0];
    endfunction

endpackage

FILE: rtl/etmb_sincos.sv
// ============================================================================
// etmb_sincos
// Sine and cosine of one angle from a quarter-wave ROM with two registered
// read ports; the signed Q16 values follow in the cycle after the angle.
// ============================================================================
module etmb_sincos #(
    parameter int unsigned ANGLE_BITS      = etmb_pkg::ANGLE_BITS_DEF,
    parameter int unsigned SINE_TABLE_BITS = etmb_pkg::SINE_TABLE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic [ANGLE_BITS-1:0] i_angle,
    output etmb_pkg::t_trig       o_trig
);

    localparam int unsigned TBL_N = 1 << SINE_TABLE_BITS;
    localparam int unsigned ADR_W = SINE_TABLE_BITS + 1;
    localparam int unsigned PH_W  = ANGLE_BITS - 2;
    localparam int          SH    = int'(PH_W) - int'(SINE_TABLE_BITS);

    typedef logic [etmb_pkg::TBL_VAL_W-1:0] t_rom [0:TBL_N];

    function automatic t_rom build_rom();
        t_rom rom;
        for (int unsigned i = 0; i <= TBL_N; i++) begin
            rom[i] = etmb_pkg::sine_entry(i, SINE_TABLE_BITS);
        end
        return rom;
    endfunction

    localparam t_rom SINE_ROM = build_rom();

    logic [PH_W-1:0]  phase;
    logic [1:0]       quad;
    logic [ADR_W-1:0] idx;
    logic [ADR_W-1:0] idx_mirror;
    logic [ADR_W-1:0] sin_addr;
    logic [ADR_W-1:0] cos_addr;

    logic [etmb_pkg::TBL_VAL_W-1:0] r_sin_mag;
    logic [etmb_pkg::TBL_VAL_W-1:0] r_cos_mag;
    logic                           r_sin_neg;
    logic                           r_cos_neg;

    assign phase = i_angle[PH_W-1:0];
    assign quad  = i_angle[ANGLE_BITS-1 -: 2];

    // Bring the phase to table resolution, rounding half up when bits drop
    generate
        if (SH > 0) begin : g_round
            localparam logic [PH_W:0] HALF_LSB = (PH_W + 1)'(1) << (SH - 1);
            logic [PH_W:0] ph_sum;
            assign ph_sum = {1'b0, phase} + HALF_LSB;
            assign idx    = ADR_W'(ph_sum >> SH);
        end else if (SH == 0) begin : g_exact
            assign idx = ADR_W'(phase);
        end else begin : g_widen
            assign idx = ADR_W'(phase) << (-SH);
        end
    endgenerate

    // Odd quadrants read the table mirrored; cosine is one quadrant ahead
    assign idx_mirror = ADR_W'(TBL_N) - idx;
    assign sin_addr   = quad[0] ? idx_mirror : idx;
    assign cos_addr   = quad[0] ? idx : idx_mirror;

    // Read both ports and hold the quadrant signs
    always_ff @(posedge i_clk) begin
        r_sin_mag <= SINE_ROM[sin_addr];
        r_cos_mag <= SINE_ROM[cos_addr];
        r_sin_neg <= quad[1];
        r_cos_neg <= quad[1] ^ quad[0];
    end

    // Apply the sign
    always_comb begin
        o_trig.sin_q = r_sin_neg ? -$signed({1'b0, r_sin_mag}) : $signed({1'b0, r_sin_mag});
        o_trig.cos_q = r_cos_neg ? -$signed({1'b0, r_cos_mag}) : $signed({1'b0, r_cos_mag});
    end

endmodule

FILE: rtl/euler_trs_matrix_builder.sv
// ============================================================================
// euler_trs_matrix_builder
// Scale-rotate-translate matrix (column-major, rows 0..2) from a position,
// Y-X-Z Euler angles and a per-axis Q8.8 scale.
// ============================================================================
// Usage:
//   Raise start with an item on the i_ ports; it is taken at a clock edge
//   where start is high and busy is low. busy never rises, so one item may
//   be taken every cycle and items stream back to back.
//   Each item yields one result: the twelve Q16.16 entries on the o_col
//   ports, shown for exactly one cycle with o_valid high. Results leave
//   in the order items came in. The pipeline has six stages: table read,
//   pair products, triple products, rounding to Q32, scale product, final
//   rounding. Throughput is one item per cycle; each angle has its own
//   dual-port sine ROM so the six lookups of an item happen in the same
//   cycle.
//   The receiver cannot stall the block: results must be taken as shown.
//   Reset (i_rst_n low at a clock edge) drops every item in flight; the
//   ROM is constant and needs no clearing.
// ============================================================================
module euler_trs_matrix_builder #(
    parameter int unsigned ANGLE_BITS      = etmb_pkg::ANGLE_BITS_DEF,
    parameter int unsigned SINE_TABLE_BITS = etmb_pkg::SINE_TABLE_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic signed [etmb_pkg::POS_W-1:0]      i_pos_x,
    input  logic signed [etmb_pkg::POS_W-1:0]      i_pos_y,
    input  logic signed [etmb_pkg::POS_W-1:0]      i_pos_z,
    input  logic        [etmb_pkg::ANGLE_W-1:0]    i_angle_x,
    input  logic        [etmb_pkg::ANGLE_W-1:0]    i_angle_y,
    input  logic        [etmb_pkg::ANGLE_W-1:0]    i_angle_z,
    input  logic signed [etmb_pkg::SCALE_W-1:0]    i_scale_x,
    input  logic signed [etmb_pkg::SCALE_W-1:0]    i_scale_y,
    input  logic signed [etmb_pkg::SCALE_W-1:0]    i_scale_z,
    output logic                                   o_valid,
    output logic signed [etmb_pkg::COL_W-1:0]      o_col0_x,
    output logic signed [etmb_pkg::COL_W-1:0]      o_col0_y,
    output logic signed [etmb_pkg::COL_W-1:0]      o_col0_z,
    output logic signed [etmb_pkg::COL_W-1:0]      o_col1_x,
    output logic signed [etmb_pkg::COL_W-1:0]      o_col1_y,
    output logic signed [etmb_pkg::COL_W-1:0]      o_col1_z,
    output logic signed [etmb_pkg::COL_W-1:0]      o_col2_x,
    output logic signed [etmb_pkg::COL_W-1:0]      o_col2_y,
    output logic signed [etmb_pkg::COL_W-1:0]      o_col2_z,
    output logic signed [etmb_pkg::COL_W-1:0]      o_col3_x,
    output logic signed [etmb_pkg::COL_W-1:0]      o_col3_y,
    output logic signed [etmb_pkg::COL_W-1:0]      o_col3_z
);

    localparam int unsigned STAGES = 6;
    localparam int unsigned TRIG_W = etmb_pkg::TRIG_W;
    localparam int unsigned PAIR_W = 2 * TRIG_W - 2;   // |product| <= 2^32
    localparam int unsigned TRIP_W = 3 * TRIG_W - 4;   // |product| <= 2^48
    localparam int unsigned SUM_W  = TRIP_W + 1;       // Q48 rotation entry
    localparam int unsigned ROT_W  = SUM_W - 16;       // Q32 rotation entry
    localparam int unsigned SCL_W  = ROT_W + etmb_pkg::SCALE_W;
    localparam int unsigned COL_W  = etmb_pkg::COL_W;

    localparam logic signed [SUM_W-1:0] RND16 = SUM_W'(1) << 15;
    localparam logic signed [SCL_W-1:0] RND24 = SCL_W'(1) << 23;

    logic                   accept;
    etmb_pkg::t_side        side_in;
    etmb_pkg::t_trig        trig_x;
    etmb_pkg::t_trig        trig_y;
    etmb_pkg::t_trig        trig_z;

    logic [STAGES-1:0]      r_valid;
    etmb_pkg::t_side        r_side [0:STAGES-2];

    // Stage 2: pair products and single terms
    logic signed [PAIR_W-1:0] r_c1c3, r_s1s3, r_c3s1, r_c1s3, r_c2s3;
    logic signed [PAIR_W-1:0] r_c2c3, r_c2s1, r_c1c2, r_s1s2, r_c1s2;
    logic signed [TRIG_W-1:0] r_s2_a, r_c3_a, r_s3_a;

    // Stage 3: triple products, pairs held
    logic signed [TRIP_W-1:0] r_s1s2s3, r_c1s2s3, r_c3s1s2, r_c1c3s2;
    logic signed [PAIR_W-1:0] r_c1c3_b, r_s1s3_b, r_c3s1_b, r_c1s3_b;
    logic signed [PAIR_W-1:0] r_c2s3_b, r_c2c3_b, r_c2s1_b, r_c1c2_b;
    logic signed [TRIG_W-1:0] r_s2_b;

    // Stage 4: rotation entries in Q32
    logic signed [ROT_W-1:0]  r_rot [0:8];
    logic signed [SUM_W-1:0]  sum0, sum2, sum3, sum5;

    // Stage 5: scaled entries in Q40
    logic signed [SCL_W-1:0]  r_scl [0:8];
    logic signed [SCL_W-1:0]  scl_rnd [0:8];

    // Stage 6: output registers
    logic signed [COL_W-1:0]  r_col [0:11];

    // The pipeline never stalls
    assign busy    = 1'b0;
    assign accept  = start && !busy;
    assign o_valid = r_valid[STAGES-1];

    assign side_in = '{pos_x: i_pos_x, pos_y: i_pos_y, pos_z: i_pos_z,
                       scale_x: i_scale_x, scale_y: i_scale_y, scale_z: i_scale_z};

    // Stage 1: table lookups (pitch x, yaw y, roll z)
    etmb_sincos #(
        .ANGLE_BITS      (ANGLE_BITS),
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_sincos_x (
        .i_clk   (i_clk),
        .i_angle (ANGLE_BITS'(i_angle_x)),
        .o_trig  (trig_x)
    );

    etmb_sincos #(
        .ANGLE_BITS      (ANGLE_BITS),
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_sincos_y (
        .i_clk   (i_clk),
        .i_angle (ANGLE_BITS'(i_angle_y)),
        .o_trig  (trig_y)
    );

    etmb_sincos #(
        .ANGLE_BITS      (ANGLE_BITS),
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_sincos_z (
        .i_clk   (i_clk),
        .i_angle (ANGLE_BITS'(i_angle_z)),
        .o_trig  (trig_z)
    );

    // Advance the valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= {r_valid[STAGES-2:0], accept};
        end
    end

    // Carry position and scale along the pipeline
    always_ff @(posedge i_clk) begin
        r_side[0] <= side_in;
        for (int s = 1; s < STAGES - 1; s++) begin
            r_side[s] <= r_side[s-1];
        end
    end

    // Stage 2: pair products (c1/s1 yaw, c2/s2 pitch, c3/s3 roll)
    always_ff @(posedge i_clk) begin
        r_c1c3 <= PAIR_W'(trig_y.cos_q * trig_z.cos_q);
        r_s1s3 <= PAIR_W'(trig_y.sin_q * trig_z.sin_q);
        r_c3s1 <= PAIR_W'(trig_z.cos_q * trig_y.sin_q);
        r_c1s3 <= PAIR_W'(trig_y.cos_q * trig_z.sin_q);
        r_c2s3 <= PAIR_W'(trig_x.cos_q * trig_z.sin_q);
        r_c2c3 <= PAIR_W'(trig_x.cos_q * trig_z.cos_q);
        r_c2s1 <= PAIR_W'(trig_x.cos_q * trig_y.sin_q);
        r_c1c2 <= PAIR_W'(trig_y.cos_q * trig_x.cos_q);
        r_s1s2 <= PAIR_W'(trig_y.sin_q * trig_x.sin_q);
        r_c1s2 <= PAIR_W'(trig_y.cos_q * trig_x.sin_q);
        r_s2_a <= trig_x.sin_q;
        r_c3_a <= trig_z.cos_q;
        r_s3_a <= trig_z.sin_q;
    end

    // Stage 3: triple products, hold the pairs used later
    always_ff @(posedge i_clk) begin
        r_s1s2s3 <= TRIP_W'(r_s1s2 * r_s3_a);
        r_c1s2s3 <= TRIP_W'(r_c1s2 * r_s3_a);
        r_c3s1s2 <= TRIP_W'(r_s1s2 * r_c3_a);
        r_c1c3s2 <= TRIP_W'(r_c1s2 * r_c3_a);
        r_c1c3_b <= r_c1c3;
        r_s1s3_b <= r_s1s3;
        r_c3s1_b <= r_c3s1;
        r_c1s3_b <= r_c1s3;
        r_c2s3_b <= r_c2s3;
        r_c2c3_b <= r_c2c3;
        r_c2s1_b <= r_c2s1;
        r_c1c2_b <= r_c1c2;
        r_s2_b   <= r_s2_a;
    end

    // Stage 4: combine to Q48 and round half up to Q32
    always_comb begin
        sum0 = (SUM_W'(r_c1c3_b) <<< 16) + SUM_W'(r_s1s2s3);
        sum2 = SUM_W'(r_c1s2s3) - (SUM_W'(r_c3s1_b) <<< 16);
        sum3 = SUM_W'(r_c3s1s2) - (SUM_W'(r_c1s3_b) <<< 16);
        sum5 = SUM_W'(r_c1c3s2) + (SUM_W'(r_s1s3_b) <<< 16);
    end

    // Entries built from one pair carry no fraction below Q32
    always_ff @(posedge i_clk) begin
        r_rot[0] <= ROT_W'((sum0 + RND16) >>> 16);
        r_rot[1] <= ROT_W'(r_c2s3_b);
        r_rot[2] <= ROT_W'((sum2 + RND16) >>> 16);
        r_rot[3] <= ROT_W'((sum3 + RND16) >>> 16);
        r_rot[4] <= ROT_W'(r_c2c3_b);
        r_rot[5] <= ROT_W'((sum5 + RND16) >>> 16);
        r_rot[6] <= ROT_W'(r_c2s1_b);
        r_rot[7] <= -(ROT_W'(r_s2_b) <<< 16);
        r_rot[8] <= ROT_W'(r_c1c2_b);
    end

    // Stage 5: multiply each column by its axis scale
    always_ff @(posedge i_clk) begin
        r_scl[0] <= SCL_W'(r_rot[0] * r_side[3].scale_x);
        r_scl[1] <= SCL_W'(r_rot[1] * r_side[3].scale_x);
        r_scl[2] <= SCL_W'(r_rot[2] * r_side[3].scale_x);
        r_scl[3] <= SCL_W'(r_rot[3] * r_side[3].scale_y);
        r_scl[4] <= SCL_W'(r_rot[4] * r_side[3].scale_y);
        r_scl[5] <= SCL_W'(r_rot[5] * r_side[3].scale_y);
        r_scl[6] <= SCL_W'(r_rot[6] * r_side[3].scale_z);
        r_scl[7] <= SCL_W'(r_rot[7] * r_side[3].scale_z);
        r_scl[8] <= SCL_W'(r_rot[8] * r_side[3].scale_z);
    end

    // Stage 6: round half up to Q16.16 and attach the position
    always_comb begin
        for (int e = 0; e < 9; e++) begin
            scl_rnd[e] = (r_scl[e] + RND24) >>> 24;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int e = 0; e < 9; e++) begin
            r_col[e] <= scl_rnd[e][COL_W-1:0];
        end
        r_col[9]  <= r_side[STAGES-2].pos_x;
        r_col[10] <= r_side[STAGES-2].pos_y;
        r_col[11] <= r_side[STAGES-2].pos_z;
    end

    assign o_col0_x = r_col[0];
    assign o_col0_y = r_col[1];
    assign o_col0_z = r_col[2];
    assign o_col1_x = r_col[3];
    assign o_col1_y = r_col[4];
    assign o_col1_z = r_col[5];
    assign o_col2_x = r_col[6];
    assign o_col2_y = r_col[7];
    assign o_col2_z = r_col[8];
    assign o_col3_x = r_col[9];
    assign o_col3_y = r_col[10];
    assign o_col3_z = r_col[11];

endmodule

FILE: sim/euler_trs_matrix_builder_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// euler_trs_matrix_builder_tb
// Streams transforms (position, Y-X-Z Euler angles, Q8.8 scale) into the
// matrix builder with random sender gaps and drain pauses. An independent
// fixed-point model works out the twelve Q16.16 entries of each matrix,
// and every result strobe is checked entry by entry, in order.
// ============================================================================
module euler_trs_matrix_builder_tb;

    localparam int unsigned POS_W               = etmb_pkg::POS_W;
    localparam int unsigned ANGLE_W             = etmb_pkg::ANGLE_W;
    localparam int unsigned SCALE_W             = etmb_pkg::SCALE_W;
    localparam int unsigned COL_W               = etmb_pkg::COL_W;
    localparam int unsigned TBL_VAL_W           = etmb_pkg::TBL_VAL_W;
    localparam int unsigned ANGLE_BITS_DEF      = etmb_pkg::ANGLE_BITS_DEF;
    localparam int unsigned SINE_TABLE_BITS_DEF = etmb_pkg::SINE_TABLE_BITS_DEF;
    localparam logic [63:0] HALF_PI_Q62         = etmb_pkg::HALF_PI_Q62;

    localparam int unsigned TBL_SIZE   = 1 << SINE_TABLE_BITS_DEF;
    localparam int unsigned IDX_SHIFT  = ANGLE_BITS_DEF - 2 - SINE_TABLE_BITS_DEF;
    localparam int unsigned QUARTER    = 1 << (ANGLE_BITS_DEF - 2);
    localparam int          CALM_TAIL  = 200;
    localparam int          RAND_ITEMS = 1500;

    // One transform as offered on the start side
    typedef struct {
        logic signed [POS_W-1:0]   pos_x;
        logic signed [POS_W-1:0]   pos_y;
        logic signed [POS_W-1:0]   pos_z;
        logic        [ANGLE_W-1:0] angle_x;
        logic        [ANGLE_W-1:0] angle_y;
        logic        [ANGLE_W-1:0] angle_z;
        logic signed [SCALE_W-1:0] scale_x;
        logic signed [SCALE_W-1:0] scale_y;
        logic signed [SCALE_W-1:0] scale_z;
        bit                        drain;
    } t_transform;

    // Twelve matrix entries, index 3*column + row
    typedef logic [11:0][COL_W-1:0] t_matrix;

    logic                      i_clk   = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      start   = 1'b0;
    logic                      busy;
    logic signed [POS_W-1:0]   i_pos_x   = '0;
    logic signed [POS_W-1:0]   i_pos_y   = '0;
    logic signed [POS_W-1:0]   i_pos_z   = '0;
    logic        [ANGLE_W-1:0] i_angle_x = '0;
    logic        [ANGLE_W-1:0] i_angle_y = '0;
    logic        [ANGLE_W-1:0] i_angle_z = '0;
    logic signed [SCALE_W-1:0] i_scale_x = '0;
    logic signed [SCALE_W-1:0] i_scale_y = '0;
    logic signed [SCALE_W-1:0] i_scale_z = '0;
    logic                      o_valid;
    logic signed [COL_W-1:0]   o_col0_x, o_col0_y, o_col0_z;
    logic signed [COL_W-1:0]   o_col1_x, o_col1_y, o_col1_z;
    logic signed [COL_W-1:0]   o_col2_x, o_col2_y, o_col2_z;
    logic signed [COL_W-1:0]   o_col3_x, o_col3_y, o_col3_z;

    logic [TBL_VAL_W-1:0] quarter_sine_rom [0:TBL_SIZE];
    t_transform           transform_queue [$];
    t_matrix              pending_matrices [$];
    int                   fail_count = 0;

    euler_trs_matrix_builder DUT (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .busy      (busy),
        .i_pos_x   (i_pos_x),
        .i_pos_y   (i_pos_y),
        .i_pos_z   (i_pos_z),
        .i_angle_x (i_angle_x),
        .i_angle_y (i_angle_y),
        .i_angle_z (i_angle_z),
        .i_scale_x (i_scale_x),
        .i_scale_y (i_scale_y),
        .i_scale_z (i_scale_z),
        .o_valid   (o_valid),
        .o_col0_x  (o_col0_x),
        .o_col0_y  (o_col0_y),
        .o_col0_z  (o_col0_z),
        .o_col1_x  (o_col1_x),
        .o_col1_y  (o_col1_y),
        .o_col1_z  (o_col1_z),
        .o_col2_x  (o_col2_x),
        .o_col2_y  (o_col2_y),
        .o_col2_z  (o_col2_z),
        .o_col3_x  (o_col3_x),
        .o_col3_y  (o_col3_y),
        .o_col3_z  (o_col3_z)
    );

    always #10 i_clk = ~i_clk;

    // Unsigned Q62 product, upper bits kept
    function automatic logic [63:0] q62_mul(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] w;
        w = 128'(a) * 128'(b);
        return 64'(w >> 62);
    endfunction

    // sin(pi/2 * idx / TBL_SIZE) in Q1.16 by Taylor series in Q62
    function automatic logic [TBL_VAL_W-1:0] quarter_sine(input int unsigned idx);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        x = (HALF_PI_Q62 >> SINE_TABLE_BITS_DEF) * 64'(idx)
          + (((HALF_PI_Q62 & 64'(TBL_SIZE - 1)) * 64'(idx)) >> SINE_TABLE_BITS_DEF);
        x2   = q62_mul(x, x);
        term = x;
        sum  = x;
        for (int k = 1; k <= 20; k++) begin
            term = q62_mul(term, x2) / 64'((2 * k) * (2 * k + 1));
            sum  = (k % 2 == 1) ? sum - term : sum + term;
        end
        return TBL_VAL_W'((sum + (64'd1 << 45)) >> 46);
    endfunction

    // Signed Q16 sine of a full-turn angle from the quarter-wave table
    function automatic longint sine_at(input logic [ANGLE_W-1:0] ang);
        int unsigned idx;
        logic [1:0]  quad;
        quad = ang[ANGLE_BITS_DEF-1 -: 2];
        idx  = ((ang % QUARTER) + (1 << (IDX_SHIFT - 1))) >> IDX_SHIFT;
        if (idx > TBL_SIZE) begin
            idx = TBL_SIZE;
        end
        if (quad[0]) begin
            idx = TBL_SIZE - idx;
        end
        return quad[1] ? -longint'(quarter_sine_rom[idx]) : longint'(quarter_sine_rom[idx]);
    endfunction

    // Q48 rotation term to Q32, times Q8.8 scale, to Q16.16; both round half up
    function automatic logic [COL_W-1:0] scaled_entry(input longint r48,
                                                      input logic signed [SCALE_W-1:0] sc);
        longint r32;
        longint p;
        r32 = (r48 + longint'(32768)) >>> 16;
        p   = r32 * longint'(sc);
        p   = (p + longint'(8388608)) >>> 24;
        return p[COL_W-1:0];
    endfunction

    // Expected matrix for one transform
    function automatic t_matrix build_matrix(input t_transform t);
        longint  c1, s1, c2, s2, c3, s3;
        t_matrix m;
        c1 = sine_at(ANGLE_W'(t.angle_y + QUARTER));
        s1 = sine_at(t.angle_y);
        c2 = sine_at(ANGLE_W'(t.angle_x + QUARTER));
        s2 = sine_at(t.angle_x);
        c3 = sine_at(ANGLE_W'(t.angle_z + QUARTER));
        s3 = sine_at(t.angle_z);
        m[0]  = scaled_entry(((c1 * c3) <<< 16) + s1 * s2 * s3, t.scale_x);
        m[1]  = scaled_entry((c2 * s3) <<< 16, t.scale_x);
        m[2]  = scaled_entry(c1 * s2 * s3 - ((c3 * s1) <<< 16), t.scale_x);
        m[3]  = scaled_entry(c3 * s1 * s2 - ((c1 * s3) <<< 16), t.scale_y);
        m[4]  = scaled_entry((c2 * c3) <<< 16, t.scale_y);
        m[5]  = scaled_entry(c1 * c3 * s2 + ((s1 * s3) <<< 16), t.scale_y);
        m[6]  = scaled_entry((c2 * s1) <<< 16, t.scale_z);
        m[7]  = scaled_entry((-s2) <<< 32, t.scale_z);
        m[8]  = scaled_entry((c1 * c2) <<< 16, t.scale_z);
        m[9]  = t.pos_x;
        m[10] = t.pos_y;
        m[11] = t.pos_z;
        return m;
    endfunction

    // Uniform angle, or one close to a quadrant boundary
    function automatic logic [ANGLE_W-1:0] pick_angle();
        if ($urandom_range(0, 3) == 0) begin
            return ANGLE_W'($urandom_range(0, 3) * QUARTER + $urandom_range(0, 32) - 16);
        end
        return ANGLE_W'($urandom);
    endfunction

    // Uniform scale, unit scale of either sign, or a range extreme
    function automatic logic [SCALE_W-1:0] pick_scale();
        case ($urandom_range(0, 3))
            0, 1: begin
                return SCALE_W'($urandom);
            end
            2: begin
                return $urandom_range(0, 1) ? 16'h0100 : 16'hFF00;
            end
            default: begin
                return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
            end
        endcase
    endfunction

    task automatic add_transform(input logic [31:0] px, input logic [31:0] py,
                                 input logic [31:0] pz, input logic [15:0] ax,
                                 input logic [15:0] ay, input logic [15:0] az,
                                 input logic [15:0] sx, input logic [15:0] sy,
                                 input logic [15:0] sz, input bit drain);
        t_transform t;
        t = '{px, py, pz, ax, ay, az, sx, sy, sz, drain};
        transform_queue.push_back(t);
    endtask

    // Driver: record the item taken at this edge, then offer the next one
    t_transform sending;
    int         gap_left = 0;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) begin
                pending_matrices.push_back(build_matrix(sending));
            end
            // hold the offered item while busy
            if (!start || !busy) begin
                if (gap_left > 0) begin
                    start <= 1'b0;
                    gap_left--;
                end else if (transform_queue.size() == 0 ||
                             (transform_queue[0].drain && pending_matrices.size() != 0)) begin
                    start <= 1'b0;
                end else if (transform_queue.size() > CALM_TAIL &&
                             $urandom_range(0, 9) == 0) begin
                    start <= 1'b0;
                    gap_left = $urandom_range(0, 18);
                end else begin
                    sending = transform_queue.pop_front();
                    start     <= 1'b1;
                    i_pos_x   <= sending.pos_x;
                    i_pos_y   <= sending.pos_y;
                    i_pos_z   <= sending.pos_z;
                    i_angle_x <= sending.angle_x;
                    i_angle_y <= sending.angle_y;
                    i_angle_z <= sending.angle_z;
                    i_scale_x <= sending.scale_x;
                    i_scale_y <= sending.scale_y;
                    i_scale_z <= sending.scale_z;
                end
            end
        end
    end

    // Monitor: compare each strobed matrix with the oldest expectation
    always @(posedge i_clk) begin
        t_matrix want;
        t_matrix got;
        if (i_rst_n && o_valid === 1'b1) begin
            got = {o_col3_z, o_col3_y, o_col3_x, o_col2_z, o_col2_y, o_col2_x,
                   o_col1_z, o_col1_y, o_col1_x, o_col0_z, o_col0_y, o_col0_x};
            if (pending_matrices.size() == 0) begin
                $error("result strobe with no item outstanding");
                fail_count++;
            end else begin
                want = pending_matrices.pop_front();
                for (int k = 0; k < 12; k++) begin
                    if (got[k] !== want[k]) begin
                        $error("col%0d_%s: expected %0d, actual %0d", k / 3,
                               (k % 3 == 0) ? "x" : (k % 3 == 1) ? "y" : "z",
                               $signed(want[k]), $signed(got[k]));
                        fail_count++;
                    end
                end
            end
        end
    end

    // Stimulus, reset and end of run
    initial begin
        for (int i = 0; i <= TBL_SIZE; i++) begin
            quarter_sine_rom[i] = quarter_sine(i);
        end

        // zero transform, then range extremes of every field
        add_transform(0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_transform(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 0, 0, 0,
                      16'h0100, 16'h0100, 16'h0100, 0);
        add_transform(32'h80000000, 32'h80000000, 32'h80000000, 16'hFFFF, 16'hFFFF,
                      16'hFFFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 0);
        add_transform(32'hFFFFFFFF, 32'h00000001, 32'hAAAA5555, 16'h4000, 16'h8000,
                      16'hC000, 16'h8000, 16'h8000, 16'h8000, 0);
        // table index rounding and the clamp at the top of a quadrant
        add_transform(1, 2, 3, 16'h0008, 16'h0007, 16'h0018, 16'h7FFF, 16'h8000, 16'h0100, 0);
        add_transform(4, 5, 6, 16'h3FF8, 16'h3FFF, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF, 0);
        add_transform(7, 8, 9, 16'hBFF8, 16'hFFF8, 16'h7FF7, 16'h7FFF, 16'h7FFF, 16'h8000, 0);
        add_transform(0, 0, 0, 16'h4008, 16'hC007, 16'h8008, 16'h0100, 16'h0100, 16'h0100, 0);
        // negative scale mirrors a column; tiny scales exercise rounding
        add_transform(32'h00010000, 32'hFFFF0000, 0, 16'h2000, 16'h2000, 16'h2000,
                      16'hFF00, 16'hFF00, 16'hFF00, 0);
        add_transform(0, 0, 0, 16'h2000, 16'h6000, 16'hA000, 16'hFFFF, 16'h0001, 16'hFFFF, 0);
        add_transform(0, 0, 0, 16'h1555, 16'hE000, 16'h5555, 16'h0001, 16'hFFFF, 16'h0001, 0);
        add_transform(0, 0, 0, 16'h8000, 16'h4000, 16'h0000, 16'hFF00, 16'h0100, 16'hFF00, 0);
        add_transform(0, 0, 0, 16'hC000, 16'hC000, 16'h4000, 16'h8001, 16'h7F00, 16'h0080, 0);
        add_transform(32'h5555AAAA, 32'h12345678, 32'h87654321, 16'h5555, 16'hAAAA,
                      16'h0F0F, 16'h5555, 16'hAAAA, 16'h00FF, 0);

        // random transforms; drain the pipe now and then before sending
        for (int i = 0; i < RAND_ITEMS; i++) begin
            add_transform($urandom, $urandom, $urandom, pick_angle(), pick_angle(),
                          pick_angle(), pick_scale(), pick_scale(), pick_scale(),
                          (i % 500) == 0 || (i % 500) == 250);
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do @(negedge i_clk); while (transform_queue.size() != 0 || start);
        for (int n = 0; n < 64 && pending_matrices.size() != 0; n++) begin
            @(negedge i_clk);
        end
        repeat (12) @(posedge i_clk);
        if (pending_matrices.size() != 0) begin
            $error("%0d results never arrived", pending_matrices.size());
            fail_count++;
        end

        if (fail_count == 0) begin
            $display("euler_trs_matrix_builder: match");
        end else begin
            $display("euler_trs_matrix_builder: mismatch");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #4_000_000;
        $display("euler_trs_matrix_builder: mismatch");
        $finish;
    end

endmodule
